// ===== hdl/id3fp_pkg.sv =====
package id3fp_pkg;

  typedef enum logic [2:0] {
    K_FRAME = 3'd0,
    K_TEXT  = 3'd1,
    K_END   = 3'd2,
    K_NOTAG = 3'd3,
    K_TRUNC = 3'd4,
    K_OVER  = 3'd5
  } kind_t;

  localparam logic [23:0] ID3_MARK       = 24'h494433;
  localparam logic [7:0]  TEXT_ID_CHAR   = 8'h54;
  localparam logic [7:0]  SYNCHSAFE_VER  = 8'd4;
  localparam logic [3:0]  HDR_LEN        = 4'd10;
  localparam logic [3:0]  MAGIC_LEN      = 4'd3;
  localparam logic [3:0]  VER_POS        = 4'd3;
  localparam logic [3:0]  SIZE_POS       = 4'd6;
  localparam logic [3:0]  ID_END         = 4'd4;
  localparam logic [3:0]  SIZE_END       = 4'd8;
  localparam int unsigned QUEUE_DEPTH    = 4;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] frame_tag;
    logic [31:0] frame_length;
    logic [15:0] frame_flag_bits;
    logic [7:0]  tag_version;
    logic [7:0]  text_char;
    logic        last_of_run;
  } result_t;

endpackage

// ===== hdl/id3fp_byte_if.sv =====
interface id3fp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source(output valid, output data_byte, output end_of_file, input ready);
  modport sink(input valid, input data_byte, input end_of_file, output ready);
endinterface

// ===== hdl/id3fp_result_if.sv =====
interface id3fp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] frame_tag;
  logic [31:0] frame_length;
  logic [15:0] frame_flag_bits;
  logic [7:0]  tag_version;
  logic [7:0]  text_char;
  logic        last_of_run;

  modport source(output valid, output kind, output frame_tag, output frame_length,
                 output frame_flag_bits, output tag_version, output text_char,
                 output last_of_run, input ready);
  modport sink(input valid, input kind, input frame_tag, input frame_length,
               input frame_flag_bits, input tag_version, input text_char,
               input last_of_run, output ready);
endinterface

// ===== hdl/id3v2_frame_parser.sv =====
// ID3v2 tag walker taking one file byte per cycle on byte_in while it is ready.
// Each accepted byte updates the parse state in the same cycle and yields zero,
// one or two result records, written into a QDEPTH-entry result queue (four by
// default); results are registered in the queue and shown on result_out from its
// head. byte_in is ready while the queue has room for two records, so with
// result_out taken every cycle the block sustains one byte per cycle; each byte
// that yields two records (an empty frame record plus tag end, or a record plus
// truncation) leaves one record more to drain, which the queue absorbs until it
// fills. The queue's output gives one record per cycle while result_out is ready.
module id3v2_frame_parser #(
  parameter int unsigned QDEPTH = id3fp_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  id3fp_byte_if.sink            byte_in,
  id3fp_result_if.source        result_out
);

  localparam int unsigned PW = $clog2(QDEPTH);
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    PH_TAGHDR,
    PH_FRAMEHDR,
    PH_PAYLOAD,
    PH_DRAIN,
    PH_IDLE
  } phase_t;

  phase_t      parse_phase, parse_phase_next;
  logic [3:0]  header_count, header_count_next;
  logic [23:0] magic_shift, magic_shift_next;
  logic [7:0]  major_ver, major_ver_next;
  logic [27:0] tag_bytes, tag_bytes_next;
  logic [28:0] tag_consumed, tag_consumed_next;
  logic [31:0] cur_id, cur_id_next;
  logic [31:0] cur_size, cur_size_next;
  logic [15:0] cur_flags, cur_flags_next;
  logic [31:0] payload_index, payload_index_next;
  logic        text_on, text_on_next;
  logic        text_halted, text_halted_next;

  id3fp_pkg::kind_t     em_kind [2];
  logic [7:0]           em_char [2];
  logic [1:0]           em_count;
  id3fp_pkg::result_t   rec [2];

  id3fp_pkg::result_t   queue [QDEPTH];
  logic [PW-1:0]        wr_ptr, rd_ptr;
  logic [CW-1:0]        count;

  logic accept, pop;
  logic [7:0] b;
  logic body_done;

  assign b      = byte_in.data_byte;
  assign accept = byte_in.valid && byte_in.ready;
  assign pop    = result_out.valid && result_out.ready;

  // Leave room for the two records one byte can produce.
  assign byte_in.ready = (count <= CW'(QDEPTH - 2));

  always_comb begin
    parse_phase_next   = parse_phase;
    header_count_next  = header_count;
    magic_shift_next   = magic_shift;
    major_ver_next     = major_ver;
    tag_bytes_next     = tag_bytes;
    tag_consumed_next  = tag_consumed;
    cur_id_next        = cur_id;
    cur_size_next      = cur_size;
    cur_flags_next     = cur_flags;
    payload_index_next = payload_index;
    text_on_next       = text_on;
    text_halted_next   = text_halted;
    em_kind[0] = id3fp_pkg::K_FRAME;
    em_kind[1] = id3fp_pkg::K_FRAME;
    em_char[0] = 8'd0;
    em_char[1] = 8'd0;
    em_count   = 2'd0;
    body_done  = 1'b0;

    case (parse_phase)
      PH_TAGHDR: begin
        if (header_count < id3fp_pkg::MAGIC_LEN) begin
          magic_shift_next = {magic_shift[15:0], b};
        end else if (header_count == id3fp_pkg::VER_POS) begin
          major_ver_next = b;
        end else if (header_count >= id3fp_pkg::SIZE_POS) begin
          tag_bytes_next = {tag_bytes[20:0], b[6:0]};
        end
        header_count_next = header_count + 4'd1;
        if (header_count_next >= id3fp_pkg::HDR_LEN) begin
          header_count_next = 4'd0;
          tag_consumed_next = 29'd0;
          if (magic_shift_next != id3fp_pkg::ID3_MARK) begin
            em_kind[em_count[0]] = id3fp_pkg::K_NOTAG;
            em_count = em_count + 2'd1;
            parse_phase_next = PH_IDLE;
          end else if (tag_bytes_next == 28'd0) begin
            em_kind[em_count[0]] = id3fp_pkg::K_END;
            em_count = em_count + 2'd1;
            parse_phase_next = PH_IDLE;
          end else begin
            parse_phase_next = PH_FRAMEHDR;
          end
        end
      end
      PH_FRAMEHDR: begin
        tag_consumed_next = tag_consumed + 29'd1;
        body_done = (tag_consumed_next >= {1'b0, tag_bytes});
        if (header_count == 4'd0 && b == 8'd0) begin
          // Padding: end of frames, drain the rest of the body.
          em_kind[em_count[0]] = id3fp_pkg::K_END;
          em_count = em_count + 2'd1;
          parse_phase_next = body_done ? PH_IDLE : PH_DRAIN;
        end else begin
          if (header_count == 4'd0) begin
            cur_id_next    = 32'd0;
            cur_size_next  = 32'd0;
            cur_flags_next = 16'd0;
          end
          if (header_count < id3fp_pkg::ID_END) begin
            cur_id_next = {cur_id_next[23:0], b};
          end else if (header_count < id3fp_pkg::SIZE_END) begin
            if (major_ver == id3fp_pkg::SYNCHSAFE_VER) begin
              cur_size_next = {4'd0, cur_size_next[20:0], b[6:0]};
            end else begin
              cur_size_next = {cur_size_next[23:0], b};
            end
          end else begin
            cur_flags_next = {cur_flags_next[7:0], b};
          end
          header_count_next = header_count + 4'd1;
          if (header_count_next < id3fp_pkg::HDR_LEN) begin
            // Header crossing the tag end closes the tag.
            if (body_done) begin
              header_count_next = 4'd0;
              em_kind[em_count[0]] = id3fp_pkg::K_END;
              em_count = em_count + 2'd1;
              parse_phase_next = PH_IDLE;
            end
          end else begin
            header_count_next = 4'd0;
            if ({4'd0, tag_consumed_next} + {1'b0, cur_size_next} > {5'd0, tag_bytes}) begin
              em_kind[em_count[0]] = id3fp_pkg::K_OVER;
              em_count = em_count + 2'd1;
              parse_phase_next = body_done ? PH_IDLE : PH_DRAIN;
            end else begin
              em_kind[em_count[0]] = id3fp_pkg::K_FRAME;
              em_count = em_count + 2'd1;
              payload_index_next = 32'd0;
              text_on_next = (cur_id_next[31:24] == id3fp_pkg::TEXT_ID_CHAR) &&
                             (cur_size_next > 32'd1);
              text_halted_next = 1'b0;
              if (cur_size_next == 32'd0) begin
                if (body_done) begin
                  em_kind[em_count[0]] = id3fp_pkg::K_END;
                  em_count = em_count + 2'd1;
                  parse_phase_next = PH_IDLE;
                end
              end else begin
                parse_phase_next = PH_PAYLOAD;
              end
            end
          end
        end
      end
      PH_PAYLOAD: begin
        tag_consumed_next = tag_consumed + 29'd1;
        body_done = (tag_consumed_next >= {1'b0, tag_bytes});
        // Skip the encoding byte and the last payload byte; stop at a zero.
        if (text_on && !text_halted && payload_index != 32'd0 &&
            ({1'b0, payload_index} + 33'd1 < {1'b0, cur_size})) begin
          if (b == 8'd0) begin
            text_halted_next = 1'b1;
          end else begin
            em_kind[em_count[0]] = id3fp_pkg::K_TEXT;
            em_char[em_count[0]] = b;
            em_count = em_count + 2'd1;
          end
        end
        payload_index_next = payload_index + 32'd1;
        if (payload_index_next >= cur_size) begin
          parse_phase_next  = PH_FRAMEHDR;
          header_count_next = 4'd0;
          if (body_done) begin
            em_kind[em_count[0]] = id3fp_pkg::K_END;
            em_count = em_count + 2'd1;
            parse_phase_next = PH_IDLE;
          end
        end
      end
      PH_DRAIN: begin
        tag_consumed_next = tag_consumed + 29'd1;
        if (tag_consumed_next >= {1'b0, tag_bytes}) begin
          parse_phase_next = PH_IDLE;
        end
      end
      default: begin
      end
    endcase

    if (byte_in.end_of_file && !em_count[1]) begin
      if (parse_phase_next == PH_TAGHDR) begin
        em_kind[em_count[0]] = id3fp_pkg::K_NOTAG;
        em_count = em_count + 2'd1;
      end else if (parse_phase_next != PH_IDLE) begin
        em_kind[em_count[0]] = id3fp_pkg::K_TRUNC;
        em_count = em_count + 2'd1;
      end
    end

    for (int i = 0; i < 2; i++) begin
      rec[i].kind = em_kind[i];
      if (em_kind[i] == id3fp_pkg::K_FRAME || em_kind[i] == id3fp_pkg::K_TEXT ||
          em_kind[i] == id3fp_pkg::K_OVER) begin
        rec[i].frame_tag       = cur_id_next;
        rec[i].frame_length    = cur_size_next;
        rec[i].frame_flag_bits = cur_flags_next;
      end else begin
        rec[i].frame_tag       = 32'd0;
        rec[i].frame_length    = 32'd0;
        rec[i].frame_flag_bits = 16'd0;
      end
      rec[i].tag_version = major_ver_next;
      rec[i].text_char   = (em_kind[i] == id3fp_pkg::K_TEXT) ? em_char[i] : 8'd0;
    end
    rec[0].last_of_run = (em_count == 2'd1);
    rec[1].last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase   <= PH_TAGHDR;
      header_count  <= 4'd0;
      magic_shift   <= 24'd0;
      major_ver     <= 8'd0;
      tag_bytes     <= 28'd0;
      tag_consumed  <= 29'd0;
      cur_id        <= 32'd0;
      cur_size      <= 32'd0;
      cur_flags     <= 16'd0;
      payload_index <= 32'd0;
      text_on       <= 1'b0;
      text_halted   <= 1'b0;
    end else if (accept) begin
      if (byte_in.end_of_file) begin
        // Back to the start for the next file.
        parse_phase   <= PH_TAGHDR;
        header_count  <= 4'd0;
        magic_shift   <= 24'd0;
        major_ver     <= 8'd0;
        tag_bytes     <= 28'd0;
        tag_consumed  <= 29'd0;
        cur_id        <= 32'd0;
        cur_size      <= 32'd0;
        cur_flags     <= 16'd0;
        payload_index <= 32'd0;
        text_on       <= 1'b0;
        text_halted   <= 1'b0;
      end else begin
        parse_phase   <= parse_phase_next;
        header_count  <= header_count_next;
        magic_shift   <= magic_shift_next;
        major_ver     <= major_ver_next;
        tag_bytes     <= tag_bytes_next;
        tag_consumed  <= tag_consumed_next;
        cur_id        <= cur_id_next;
        cur_size      <= cur_size_next;
        cur_flags     <= cur_flags_next;
        payload_index <= payload_index_next;
        text_on       <= text_on_next;
        text_halted   <= text_halted_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && em_count != 2'd0) begin
      queue[wr_ptr] <= rec[0];
    end
    if (accept && em_count[1]) begin
      queue[wr_ptr + PW'(1)] <= rec[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + PW'(em_count);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + (accept ? CW'(em_count) : CW'(0)) - (pop ? CW'(1) : CW'(0));
    end
  end

  assign result_out.valid           = (count != '0);
  assign result_out.kind            = queue[rd_ptr].kind;
  assign result_out.frame_tag       = queue[rd_ptr].frame_tag;
  assign result_out.frame_length    = queue[rd_ptr].frame_length;
  assign result_out.frame_flag_bits = queue[rd_ptr].frame_flag_bits;
  assign result_out.tag_version     = queue[rd_ptr].tag_version;
  assign result_out.text_char       = queue[rd_ptr].text_char;
  assign result_out.last_of_run     = queue[rd_ptr].last_of_run;

endmodule

// ===== hdl/id3fp_checker.sv =====
module id3fp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  kind,
  input logic [31:0] frame_tag,
  input logic [31:0] frame_length,
  input logic [15:0] frame_flag_bits,
  input logic [7:0]  text_char,
  input logic        last_of_run
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(kind) && $stable(frame_tag) &&
      $stable(text_char) && $stable(last_of_run))
    else $error("result changed while stalled");

  a_text_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == id3fp_pkg::K_TEXT |-> text_char != 8'd0)
    else $error("text byte of zero emitted");

  // Tag end is exempt from the last-of-run check.
  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == id3fp_pkg::K_END || kind == id3fp_pkg::K_NOTAG ||
      kind == id3fp_pkg::K_TRUNC) |->
      frame_tag == 32'd0 && frame_length == 32'd0 && frame_flag_bits == 16'd0 &&
      (last_of_run || kind == id3fp_pkg::K_END))
    else $error("status result carries frame fields or is not last");

endmodule

bind id3v2_frame_parser id3fp_checker u_id3fp_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (result_out.valid),
  .out_ready       (result_out.ready),
  .kind            (result_out.kind),
  .frame_tag       (result_out.frame_tag),
  .frame_length    (result_out.frame_length),
  .frame_flag_bits (result_out.frame_flag_bits),
  .text_char       (result_out.text_char),
  .last_of_run     (result_out.last_of_run)
);
